[src/morse_key_decoder_defines.svh]
// assertion macros shared by the morse key decoder rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef MORSE_KEY_DECODER_DEFINES_SVH
`define MORSE_KEY_DECODER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define MKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define MKD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/mkd_pkg.sv]
// types, constants and the glyph lookup for the morse key decoder
// no dependencies
`default_nettype none

package mkd_pkg;

  localparam int unsigned TickW     = 16;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned MaxSymbols = 5;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [TickW-1:0] DotMinReset  = 16'd1875;
  localparam logic [TickW-1:0] DashMinReset = 16'd12500;
  localparam logic [TickW-1:0] DashMaxReset = 16'd25000;

  // event codes on the request channel
  typedef enum logic [1:0] {
    OP_PRESS    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_OVERFLOW = 2'd2,
    OP_TIMEOUT  = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOT_MIN  = 2'd0,
    CFG_DASH_MIN = 2'd1,
    CFG_DASH_MAX = 2'd2
  } cfg_idx_e;

  // press classification
  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_DOT  = 2'd1,
    SYM_DASH = 2'd2
  } sym_e;

  // overflow counter values
  localparam logic [1:0] OvfNone = 2'd0;
  localparam logic [1:0] OvfOne  = 2'd1;
  localparam logic [1:0] OvfSat  = 2'd2;

  // ascii for index (1 << n) | pattern, first symbol in the msb, zero when unknown
  function automatic logic [CodeW-1:0] glyph_code(input logic [5:0] idx);
    logic [CodeW-1:0] c;
    c = '0;
    case (idx)
      6'd2:    c = 7'h45; // E
      6'd3:    c = 7'h54; // T
      6'd4:    c = 7'h49; // I
      6'd5:    c = 7'h41; // A
      6'd6:    c = 7'h4E; // N
      6'd7:    c = 7'h4D; // M
      6'd8:    c = 7'h53; // S
      6'd9:    c = 7'h55; // U
      6'd10:   c = 7'h52; // R
      6'd11:   c = 7'h57; // W
      6'd12:   c = 7'h44; // D
      6'd13:   c = 7'h4B; // K
      6'd14:   c = 7'h47; // G
      6'd15:   c = 7'h4F; // O
      6'd16:   c = 7'h48; // H
      6'd17:   c = 7'h56; // V
      6'd18:   c = 7'h46; // F
      6'd20:   c = 7'h4C; // L
      6'd22:   c = 7'h50; // P
      6'd23:   c = 7'h4A; // J
      6'd24:   c = 7'h42; // B
      6'd25:   c = 7'h58; // X
      6'd26:   c = 7'h43; // C
      6'd27:   c = 7'h59; // Y
      6'd28:   c = 7'h5A; // Z
      6'd29:   c = 7'h51; // Q
      6'd32:   c = 7'h35; // 5
      6'd33:   c = 7'h34; // 4
      6'd35:   c = 7'h33; // 3
      6'd39:   c = 7'h32; // 2
      6'd47:   c = 7'h31; // 1
      6'd48:   c = 7'h36; // 6
      6'd56:   c = 7'h37; // 7
      6'd60:   c = 7'h38; // 8
      6'd62:   c = 7'h39; // 9
      6'd63:   c = 7'h30; // 0
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/mkd_classify.sv]
// press length measurement and dot/dash classification
// depends on mkd_pkg
`default_nettype none

module mkd_classify
  import mkd_pkg::*;
(
  input  logic [TickW-1:0] press_time_i,
  input  logic [TickW-1:0] release_time_i,
  input  logic [1:0]       overflow_count_i,
  input  logic [TickW-1:0] dot_min_i,
  input  logic [TickW-1:0] dash_min_i,
  input  logic [TickW-1:0] dash_max_i,
  output sym_e             symbol_o
);

  logic [TickW:0] diff;
  logic [TickW:0] len;
  logic [TickW:0] dot_min_x;
  logic [TickW:0] dash_min_x;
  logic [TickW:0] dash_max_x;

  // length wraps once per counter overflow seen during the hold
  assign diff = {1'b0, release_time_i} - {1'b0, press_time_i};
  assign len  = (overflow_count_i == OvfOne) ? {1'b1, {TickW{1'b0}}} + diff
                                             : {1'b0, diff[TickW-1:0]};

  assign dot_min_x  = {1'b0, dot_min_i};
  assign dash_min_x = {1'b0, dash_min_i};
  assign dash_max_x = {1'b0, dash_max_i};

  // dot test first, then dash window; short, long or twice wrapped holds are dropped
  always_comb begin
    symbol_o = SYM_NONE;
    if (overflow_count_i == OvfNone || overflow_count_i == OvfOne) begin
      if (len >= dot_min_x && len < dash_min_x) begin
        symbol_o = SYM_DOT;
      end else if (len >= dash_min_x && len < dash_max_x) begin
        symbol_o = SYM_DASH;
      end
    end
  end

endmodule

`default_nettype wire

[src/mkd_glyph.sv]
// pattern to character lookup for the buffered symbols
// depends on mkd_pkg
`default_nettype none

module mkd_glyph
  import mkd_pkg::*;
(
  input  logic [CountW-1:0]     count_i,
  input  logic [MaxSymbols-1:0] bits_i,
  output logic [CodeW-1:0]      code_o
);

  logic [5:0] idx;

  // leading one marks the length, first symbol lands in the msb
  always_comb begin
    idx = 6'd0;
    case (count_i)
      3'd1:    idx = {5'b00001, bits_i[0]};
      3'd2:    idx = {4'b0001, bits_i[0], bits_i[1]};
      3'd3:    idx = {3'b001, bits_i[0], bits_i[1], bits_i[2]};
      3'd4:    idx = {2'b01, bits_i[0], bits_i[1], bits_i[2], bits_i[3]};
      3'd5:    idx = {1'b1, bits_i[0], bits_i[1], bits_i[2], bits_i[3], bits_i[4]};
      default: idx = 6'd0;
    endcase
  end

  assign code_o = glyph_code(idx);

endmodule

`default_nettype wire

[src/morse_key_decoder.sv]
// morse key decoder top level: input register, decode logic, result register
// a request held in the input register has its result registered in the result register when it advances
// throughput: one request per cycle while the output is not stalled, set by the single decode pass between registers
// while a result waits behind out_stall_i the input register takes one more request, then stalls
// reset clears key state, symbol buffer, lamps and loads threshold defaults
// depends on mkd_pkg, mkd_classify, mkd_glyph, morse_key_decoder_defines.svh
`default_nettype none
`include "morse_key_decoder_defines.svh"

module morse_key_decoder
  import mkd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // event requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [TickW-1:0]   timestamp_i,
  // decoded results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               char_valid_o,
  output logic [CodeW-1:0]   char_code_o,
  output logic               invalid_char_o,
  output logic               dot_led_o,
  output logic               dash_led_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i
);

  // thresholds
  logic [TickW-1:0] dot_min_q, dash_min_q, dash_max_q;

  // input register
  logic             in_vld_q;
  logic [1:0]       in_op_q;
  logic [TickW-1:0] in_ts_q;

  // result register
  logic             out_vld_q;
  logic             char_valid_q, char_valid_d;
  logic [CodeW-1:0] char_code_q, char_code_d;
  logic             invalid_q, invalid_d;

  // decoder state
  logic [TickW-1:0]      press_time_q, press_time_d;
  logic [1:0]            ovf_cnt_q, ovf_cnt_d;
  logic [CountW-1:0]     sym_cnt_q, sym_cnt_d;
  logic [MaxSymbols-1:0] sym_bits_q, sym_bits_d;
  logic                  key_down_q, key_down_d;
  logic                  dot_lamp_q, dot_lamp_d;
  logic                  dash_lamp_q, dash_lamp_d;

  logic             out_free;
  logic             advance;
  logic             in_load;
  sym_e             symbol;
  logic [CodeW-1:0] glyph;
  op_e              op;

  // handshake between the two register stages
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign op = op_e'(in_op_q);

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_min_q  <= DotMinReset;
      dash_min_q <= DashMinReset;
      dash_max_q <= DashMaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DOT_MIN:  dot_min_q  <= cfg_data_i;
        CFG_DASH_MIN: dash_min_q <= cfg_data_i;
        CFG_DASH_MAX: dash_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mkd_classify u_classify (
    .press_time_i     (press_time_q),
    .release_time_i   (in_ts_q),
    .overflow_count_i (ovf_cnt_q),
    .dot_min_i        (dot_min_q),
    .dash_min_i       (dash_min_q),
    .dash_max_i       (dash_max_q),
    .symbol_o         (symbol)
  );

  mkd_glyph u_glyph (
    .count_i (sym_cnt_q),
    .bits_i  (sym_bits_q),
    .code_o  (glyph)
  );

  // next decoder state and result for the request in the input register
  always_comb begin
    press_time_d = press_time_q;
    ovf_cnt_d    = ovf_cnt_q;
    sym_cnt_d    = sym_cnt_q;
    sym_bits_d   = sym_bits_q;
    key_down_d   = key_down_q;
    dot_lamp_d   = dot_lamp_q;
    dash_lamp_d  = dash_lamp_q;
    char_valid_d = 1'b0;
    char_code_d  = '0;
    invalid_d    = 1'b0;
    case (op)
      OP_PRESS: begin
        dot_lamp_d  = 1'b0;
        dash_lamp_d = 1'b0;
        if (!key_down_q) begin
          press_time_d = in_ts_q;
          ovf_cnt_d    = OvfNone;
          key_down_d   = 1'b1;
        end
      end
      OP_RELEASE: begin
        dot_lamp_d  = 1'b0;
        dash_lamp_d = 1'b0;
        if (key_down_q) begin
          key_down_d = 1'b0;
          if (symbol != SYM_NONE) begin
            dot_lamp_d  = (symbol == SYM_DOT);
            dash_lamp_d = (symbol == SYM_DASH);
            // full buffer: drop the symbol and the buffered ones, and flag the character
            if (sym_cnt_q >= CountW'(MaxSymbols)) begin
              sym_cnt_d  = '0;
              sym_bits_d = '0;
              invalid_d  = 1'b1;
            end else begin
              sym_bits_d[sym_cnt_q] = (symbol == SYM_DASH);
              sym_cnt_d = sym_cnt_q + CountW'(1);
            end
          end
        end
      end
      OP_OVERFLOW: begin
        if (ovf_cnt_q != OvfSat) begin
          ovf_cnt_d = ovf_cnt_q + 2'd1;
        end
      end
      OP_TIMEOUT: begin
        if (!key_down_q && sym_cnt_q != '0) begin
          char_valid_d = (glyph != '0);
          char_code_d  = glyph;
          invalid_d    = (glyph == '0);
          sym_cnt_d    = '0;
          sym_bits_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load || advance) begin
      in_vld_q <= in_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q <= opcode_i;
      in_ts_q <= timestamp_i;
    end
  end

  // decoder state, updated once per request passed to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q <= '0;
      ovf_cnt_q    <= OvfNone;
      sym_cnt_q    <= '0;
      sym_bits_q   <= '0;
      key_down_q   <= 1'b0;
      dot_lamp_q   <= 1'b0;
      dash_lamp_q  <= 1'b0;
    end else if (advance) begin
      press_time_q <= press_time_d;
      ovf_cnt_q    <= ovf_cnt_d;
      sym_cnt_q    <= sym_cnt_d;
      sym_bits_q   <= sym_bits_d;
      key_down_q   <= key_down_d;
      dot_lamp_q   <= dot_lamp_d;
      dash_lamp_q  <= dash_lamp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_valid_q <= char_valid_d;
      char_code_q  <= char_code_d;
      invalid_q    <= invalid_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign char_valid_o   = char_valid_q;
  assign char_code_o    = char_code_q;
  assign invalid_char_o = invalid_q;
  assign dot_led_o      = dot_lamp_q;
  assign dash_led_o     = dash_lamp_q;

  // checks on the decoder logic
  `MKD_ASSERT(a_sym_cnt_bound, sym_cnt_q <= CountW'(MaxSymbols), "symbol count past limit")
  `MKD_ASSERT_NEVER(a_ovf_cnt_bound, ovf_cnt_q == 2'd3, "overflow count past saturation")
  `MKD_ASSERT(a_char_flags, out_vld_q && char_valid_q |-> !invalid_q && char_code_q != '0, "char with error or empty code")
  `MKD_ASSERT(a_stall_holds_item, in_stall_o |-> in_vld_q && out_vld_q && out_stall_i, "stall without both stages full")
  `MKD_ASSERT_NEVER(a_both_lamps, dot_lamp_q && dash_lamp_q, "dot and dash lamps lit together")

endmodule

`default_nettype wire
